>>> rtl/dad_pkg.sv
// ----------------------------------------------------------------------------
// dad_pkg: shared constants and types
// Widths, command and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none
package dad_pkg;
    localparam int CAPACITY   = 1024;
    localparam int ELEM_WIDTH = 32;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = AW + 1;

    localparam logic [1:0] CMD_INSERT    = 2'd0;
    localparam logic [1:0] CMD_REMOVE    = 2'd1;
    localparam logic [1:0] CMD_READ      = 2'd2;
    localparam logic [1:0] CMD_OVERWRITE = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // memory operation issued by the controller
    typedef struct packed {
        logic          rd_en;
        logic          rd_back;   // 1: back store, 0: front store
        logic [AW-1:0] rd_addr;
        logic          wr_en;
        logic          wr_back;
        logic [AW-1:0] wr_addr;
        logic          wr_sel_in; // write data from item value, else scratch or read data
        logic          cap_res;   // capture read data as result
        logic          scr_wr;    // write read data into scratch
        logic [AW-1:0] scr_addr;
        logic          scr_rd;    // read scratch at scr_addr
        logic          wr_sel_scr;
    } t_cmd;

    typedef struct packed {
        logic [ELEM_WIDTH-1:0] rd_data;
    } t_stat;
endpackage
`default_nettype wire

>>> rtl/dad_if.sv
// ----------------------------------------------------------------------------
// dad_in_if / dad_out_if: valid/ready channels
// Input command channel and result channel.
// ----------------------------------------------------------------------------
`default_nettype none
interface dad_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [10:0] pos;
    logic [31:0] value;
    modport source (output valid, cmd, pos, value, input ready);
    modport sink   (input valid, cmd, pos, value, output ready);
endinterface

interface dad_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_out;
    logic [1:0]  status;
    logic [10:0] count;
    modport source (output valid, value_out, status, count, input ready);
    modport sink   (input valid, value_out, status, count, output ready);
endinterface
`default_nettype wire

>>> rtl/dual_array_deque.sv
// ----------------------------------------------------------------------------
// dual_array_deque: positional list in two stacks
// Sequencer plus front/back/scratch stores; one result beat per command.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  s_in    | in  | cmd[1:0], pos[10:0], value[31:0]
//  m_out   | out | value_out[31:0], status[1:0], count[10:0]
//
//  The result beat follows the read and its wait state for read/overwrite;
//  insert first shifts each entry by a read and a write; remove moves each
//  entry from the target to the top of its stack. A rebalance gathers every
//  element into scratch, then redistributes it. Bad or full: valid next cycle.
//  Reset clears the counts, the state and the result valid; stores need no clearing.
//  A new command is taken only once the previous result beat has gone.
`default_nettype none
module dual_array_deque (
    input  wire       i_clk,
    input  wire       i_rst_n,
    dad_in_if.sink    s_in,
    dad_out_if.source m_out
);
    dad_pkg::t_cmd  w_cmd;
    dad_pkg::t_stat w_stat;
    logic [31:0]    w_value;

    dad_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .s_in   (s_in),
        .m_out  (m_out),
        .o_cmd  (w_cmd),
        .o_value(w_value),
        .i_stat (w_stat)
    );

    // item value as latched at accept
    dad_datapath u_dp (
        .i_clk  (i_clk),
        .i_cmd  (w_cmd),
        .i_value(w_value),
        .o_stat (w_stat)
    );
endmodule
`default_nettype wire

>>> rtl/dad_datapath.sv
// ----------------------------------------------------------------------------
// dad_datapath: element stores
// Front, back and scratch memories with registered reads.
// ----------------------------------------------------------------------------
`default_nettype none
module dad_datapath (
    input  wire                           i_clk,
    input  wire dad_pkg::t_cmd            i_cmd,
    input  wire [dad_pkg::ELEM_WIDTH-1:0] i_value,
    output dad_pkg::t_stat                o_stat
);
    logic [dad_pkg::ELEM_WIDTH-1:0] r_front [dad_pkg::CAPACITY];
    logic [dad_pkg::ELEM_WIDTH-1:0] r_back  [dad_pkg::CAPACITY];
    logic [dad_pkg::ELEM_WIDTH-1:0] r_scr   [dad_pkg::CAPACITY];
    logic [dad_pkg::ELEM_WIDTH-1:0] r_fq, r_bq, r_sq;
    logic r_sel_back;
    logic [dad_pkg::ELEM_WIDTH-1:0] w_rd, w_wd;

    assign w_rd = r_sel_back ? r_bq : r_fq;
    assign w_wd = i_cmd.wr_sel_in ? i_value : (i_cmd.wr_sel_scr ? r_sq : w_rd);
    assign o_stat.rd_data = w_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_sel_back <= i_cmd.rd_back;
        end
        if (i_cmd.rd_en && !i_cmd.rd_back) begin
            r_fq <= r_front[i_cmd.rd_addr];
        end
        if (i_cmd.rd_en && i_cmd.rd_back) begin
            r_bq <= r_back[i_cmd.rd_addr];
        end
        if (i_cmd.wr_en && !i_cmd.wr_back) begin
            r_front[i_cmd.wr_addr] <= w_wd;
        end
        if (i_cmd.wr_en && i_cmd.wr_back) begin
            r_back[i_cmd.wr_addr] <= w_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scr_wr) begin
            r_scr[i_cmd.scr_addr] <= w_rd;
        end
        if (i_cmd.scr_rd) begin
            r_sq <= r_scr[i_cmd.scr_addr];
        end
    end
endmodule
`default_nettype wire

>>> rtl/dad_ctrl.sv
// ----------------------------------------------------------------------------
// dad_ctrl: command sequencer
// Checks positions, runs shifts and rebalance sweeps, forms the result.
// ----------------------------------------------------------------------------
`default_nettype none
module dad_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    dad_in_if.sink              s_in,
    dad_out_if.source           m_out,
    output dad_pkg::t_cmd       o_cmd,
    output wire [31:0]          o_value,
    input  wire dad_pkg::t_stat i_stat
);
    localparam int AW = dad_pkg::AW;
    localparam int CW = dad_pkg::CW;
    localparam logic [3:0] S_IDLE = 4'd0, S_SHIFT = 4'd1, S_SHW = 4'd2,
                           S_ACC = 4'd3, S_ACCW = 4'd4, S_CHK = 4'd5,
                           S_GATH = 4'd6, S_GATW = 4'd7, S_DIST = 4'd8,
                           S_DISW = 4'd9, S_OUT = 4'd10;

    logic [3:0]  r_st, n_st;
    logic [1:0]  r_op, n_op;
    logic [CW-1:0] r_f, r_b, n_f, n_b;
    logic [CW-1:0] r_i, r_k, n_i, n_k;  // sweep index, target index
    logic        r_side, n_side;        // 1: back store
    logic [31:0] r_val, r_res, n_val, n_res;
    logic [1:0]  r_status, n_status;
    logic        r_ovalid, n_ovalid;
    logic        w_acc;
    logic [CW-1:0] w_n, w_nf, w_p, w_fi;
    logic [CW+1:0] w_3f, w_3b;

    assign w_acc = s_in.valid && s_in.ready;
    assign w_n  = r_f + r_b;
    assign w_nf = w_n >> 1;
    assign w_p  = s_in.pos;
    assign w_3f = {2'b00, r_f} + {1'b0, r_f, 1'b0};
    assign w_3b = {2'b00, r_b} + {1'b0, r_b, 1'b0};
    assign w_fi = r_f - 1'b1 - r_i;   // front entry of position r_i

    assign s_in.ready      = (r_st == S_IDLE) && !r_ovalid;
    assign m_out.valid     = r_ovalid;
    assign m_out.value_out = r_res;
    assign m_out.status    = r_status;
    assign m_out.count     = w_n;
    assign o_value         = r_val;

    always_comb begin
        n_st = r_st;
        n_f = r_f; n_b = r_b; n_i = r_i; n_k = r_k;
        n_op = r_op; n_side = r_side; n_val = r_val; n_res = r_res;
        n_status = r_status;
        n_ovalid = r_ovalid;
        if (m_out.valid && m_out.ready) n_ovalid = 1'b0;
        o_cmd = '0;
        case (r_st)
            S_IDLE: begin
                if (w_acc) begin
                    n_op = s_in.cmd; n_val = s_in.value; n_res = '0;
                    n_status = dad_pkg::ST_OK;
                    if (s_in.cmd == dad_pkg::CMD_INSERT) begin
                        if (w_p > w_n) begin
                            n_status = dad_pkg::ST_BAD; n_ovalid = 1'b1;
                        end else if (w_n >= CW'(dad_pkg::CAPACITY)) begin
                            n_status = dad_pkg::ST_FULL; n_ovalid = 1'b1;
                        end else begin
                            n_st = S_SHIFT;
                        end
                        if (w_p < r_f) begin
                            n_side = 1'b0; n_i = r_f; n_k = r_f - w_p;
                        end else begin
                            n_side = 1'b1; n_i = r_b; n_k = w_p - r_f;
                        end
                    end else begin
                        if (w_p >= w_n) begin
                            n_status = dad_pkg::ST_BAD; n_ovalid = 1'b1;
                        end else begin
                            n_st = S_ACC;
                        end
                        if (w_p < r_f) begin
                            n_side = 1'b0; n_i = r_f - 1'b1 - w_p;
                            n_k = r_f - 1'b1 - w_p;
                        end else begin
                            n_side = 1'b1; n_i = w_p - r_f; n_k = w_p - r_f;
                        end
                    end
                end
            end
            // insert: move entries i-1 -> i down to k, then write
            S_SHIFT: begin
                if (r_i == r_k) begin
                    o_cmd.wr_en = 1'b1; o_cmd.wr_back = r_side;
                    o_cmd.wr_addr = r_k[AW-1:0]; o_cmd.wr_sel_in = 1'b1;
                    if (r_side) n_b = r_b + 1'b1; else n_f = r_f + 1'b1;
                    n_st = S_CHK;
                end else begin
                    o_cmd.rd_en = 1'b1; o_cmd.rd_back = r_side;
                    o_cmd.rd_addr = AW'(r_i - 1'b1);
                    n_st = S_SHW;
                end
            end
            S_SHW: begin
                o_cmd.wr_en = 1'b1; o_cmd.wr_back = r_side;
                o_cmd.wr_addr = r_i[AW-1:0];
                n_i = r_i - 1'b1;
                n_st = S_SHIFT;
            end
            // access: read entry k, then per op
            S_ACC: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_back = r_side;
                o_cmd.rd_addr = r_i[AW-1:0];
                n_st = S_ACCW;
            end
            S_ACCW: begin
                if (r_i == r_k) begin
                    o_cmd.cap_res = 1'b1;
                    n_res = i_stat.rd_data;
                end
                if (r_op == dad_pkg::CMD_OVERWRITE) begin
                    o_cmd.wr_en = 1'b1; o_cmd.wr_back = r_side;
                    o_cmd.wr_addr = r_k[AW-1:0]; o_cmd.wr_sel_in = 1'b1;
                    n_st = S_OUT;
                end else if (r_op == dad_pkg::CMD_READ) begin
                    n_st = S_OUT;
                end else begin
                    // remove: entry i -> i-1
                    if (r_i != r_k) begin
                        o_cmd.wr_en = 1'b1; o_cmd.wr_back = r_side;
                        o_cmd.wr_addr = AW'(r_i - 1'b1);
                    end
                    if (r_i + 1'b1 >= (r_side ? r_b : r_f)) begin
                        if (r_side) n_b = r_b - 1'b1; else n_f = r_f - 1'b1;
                        n_st = S_CHK;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_st = S_ACC;
                    end
                end
            end
            S_CHK: begin
                n_i = '0;
                if ((w_3f < {2'b00, r_b}) || (w_3b < {2'b00, r_f})) n_st = S_GATH;
                else n_st = S_OUT;
            end
            // gather list order into scratch
            S_GATH: begin
                if (r_i == w_n) begin
                    n_i = '0; n_st = S_DIST;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.rd_back = (r_i >= r_f);
                    o_cmd.rd_addr = (r_i < r_f) ? w_fi[AW-1:0] : AW'(r_i - r_f);
                    n_st = S_GATW;
                end
            end
            S_GATW: begin
                o_cmd.scr_wr = 1'b1; o_cmd.scr_addr = r_i[AW-1:0];
                n_i = r_i + 1'b1; n_st = S_GATH;
            end
            S_DIST: begin
                if (r_i == w_n) begin
                    n_f = w_nf; n_b = w_n - w_nf; n_st = S_OUT;
                end else begin
                    o_cmd.scr_rd = 1'b1; o_cmd.scr_addr = r_i[AW-1:0];
                    n_st = S_DISW;
                end
            end
            S_DISW: begin
                o_cmd.wr_en = 1'b1; o_cmd.wr_sel_scr = 1'b1;
                o_cmd.wr_back = (r_i >= w_nf);
                o_cmd.wr_addr = (r_i < w_nf) ? AW'(w_nf - 1'b1 - r_i)
                                             : AW'(r_i - w_nf);
                n_i = r_i + 1'b1; n_st = S_DIST;
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_f <= '0; r_b <= '0; r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st; r_f <= n_f; r_b <= n_b; r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_k <= n_k;
        r_op <= n_op; r_side <= n_side; r_val <= n_val; r_res <= n_res;
        r_status <= n_status;
    end
endmodule
`default_nettype wire
